// ----- design/cell_pair_spring_force_assert.svh -----
// Assertion macros shared by the checker of the spring force block.
`ifndef CELL_PAIR_SPRING_FORCE_ASSERT_SVH
`define CELL_PAIR_SPRING_FORCE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CPSF_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpsf: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CPSF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpsf: next-cycle check failed");

`endif

// ----- design/cpsf_pkg.sv -----
// Shared widths, constants and pipeline record types of the spring force block.
`timescale 1ns / 1ps
package cpsf_pkg;

  localparam int COORD_W   = 24;
  localparam int FRAC_BITS = 8;
  localparam int PRM_W     = 16;
  localparam int STRETCH_W = 24;
  localparam logic [STRETCH_W-1:0] MAX_STRETCH_RST = STRETCH_W'(2560);

  // Derived widths
  localparam int MAG_W       = COORD_W;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int SQ_W        = 2 * COORD_W + 2;
  localparam int ROOT_W      = COORD_W + 1;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int GAP_W       = ROOT_W + 3;
  localparam int DELTA_W     = GAP_W - 1;
  localparam int M_W         = ROOT_W + 17 - FRAC_BITS;
  localparam int NUM_W       = M_W + MAG_W;
  localparam int DIV_STAGES  = M_W;
  localparam int FORCE_W     = 32;

  // Per-item spring parameters
  typedef struct packed {
    logic [PRM_W-1:0] rs;
    logic [PRM_W-1:0] ro;
    logic [PRM_W-1:0] rest;
    logic [PRM_W-1:0] k;
    logic [PRM_W-1:0] pres;
  } prm_t;

  // Record riding alongside the square root
  typedef struct packed {
    logic                  valid;
    logic [2:0]            sgn;
    logic [2:0][MAG_W-1:0] mag;
    prm_t                  prm;
  } sq_sb_t;

  // Record riding through the scale stages
  typedef struct packed {
    logic                  valid;
    logic [2:0]            cneg;
    logic [2:0][MAG_W-1:0] mag;
    logic                  over;
    logic                  stretch;
    logic                  degen;
    logic [ROOT_W-1:0]     ctr_len;
    logic [PRM_W-1:0]      pres;
  } mid_t;

  // Record riding alongside the divider
  typedef struct packed {
    logic       valid;
    logic [2:0] cneg;
    logic       over;
    logic       stretch;
    logic       degen;
  } dv_sb_t;

endpackage

// ----- design/cpsf_isqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
`timescale 1ns / 1ps
module cpsf_isqrt import cpsf_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   rad_i,
  output logic [ROOT_W-1:0] root_o
);

  localparam int RW = ROOT_W + 3;

  logic [RW-1:0]     rem_r  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_r [SQRT_STAGES];
  logic [SQ_W-1:0]   rad_r  [SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_st
    logic [RW-1:0]     rem_in, t, trial, rem_nxt;
    logic [ROOT_W-1:0] root_in, root_nxt;
    logic [SQ_W-1:0]   rad_in;
    logic              ge;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_rest
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign rad_in  = rad_r[g-1];
    end

    // bring down the next bit pair and try root*4+1
    always_comb begin
      t        = {rem_in[RW-3:0], rad_in[SQ_W-1 -: 2]};
      trial    = RW'({root_in, 2'b01});
      ge       = (t >= trial);
      rem_nxt  = ge ? (t - trial) : t;
      root_nxt = {root_in[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= rem_nxt;
        root_r[g] <= root_nxt;
        rad_r[g]  <= {rad_in[SQ_W-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_r[SQRT_STAGES-1];

endmodule

// ----- design/cpsf_div.sv -----
// Pipelined three-lane restoring divider by a shared divisor, one quotient bit per stage.
`timescale 1ns / 1ps
module cpsf_div import cpsf_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2:0][NUM_W-1:0] num_i,
  input  logic [ROOT_W-1:0]     dist_i,
  output logic [2:0][M_W-1:0]   q_o
);

  logic [ROOT_W-1:0]          dist_r [DIV_STAGES];
  logic [2:0][ROOT_W-1:0]     rem_r  [DIV_STAGES];
  logic [2:0][M_W-1:0]        nq_r   [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_st
    logic [ROOT_W-1:0]      dist_in;
    logic [2:0][ROOT_W-1:0] rem_in, rem_nxt;
    logic [2:0][M_W-1:0]    nq_in, nq_nxt;

    if (g == 0) begin : g_first
      assign dist_in = dist_i;
      for (genvar l = 0; l < 3; l++) begin : g_ld
        // upper part is below the divisor, so it seeds the remainder
        assign rem_in[l] = ROOT_W'(num_i[l][NUM_W-1:M_W]);
        assign nq_in[l]  = num_i[l][M_W-1:0];
      end
    end else begin : g_rest
      assign dist_in = dist_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign nq_in   = nq_r[g-1];
    end

    // numerator bits shift out at the top while quotient bits shift in
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [ROOT_W:0] t;
      logic            ge;
      always_comb begin
        t          = {rem_in[l], nq_in[l][M_W-1]};
        ge         = (t >= {1'b0, dist_in});
        rem_nxt[l] = ROOT_W'(ge ? (t - {1'b0, dist_in}) : t);
        nq_nxt[l]  = {nq_in[l][M_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dist_r[g] <= dist_in;
        rem_r[g]  <= rem_nxt;
        nq_r[g]   <= nq_nxt;
      end
    end
  end

  assign q_o = nq_r[DIV_STAGES-1];

endmodule

// ----- design/cell_pair_spring_force.sv -----
// Top level of the Hooke's law spring force pipeline between two spherical cells.
// One spring request is taken per clock while in_tready is high, and one force
// result leaves per clock while out_tready is high. A request passes 68
// register stages, the first loaded at the edge that accepts it: three front
// stages (difference, squares, sum), 25 square root stages, four scale
// stages, 34 divider stages, one clipping stage and the output register. The
// square root and the per-axis division each retire one bit per stage, which
// sets the depth. A skid register behind the output lets the pipeline keep
// accepting while a result waits; in_tready drops only once both are full.
// max_stretch may be rewritten only while no request is in flight.
`timescale 1ns / 1ps
module cell_pair_spring_force import cpsf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // config
  input  logic                 cfg_wr_en,
  input  logic [STRETCH_W-1:0] cfg_wr_data,
  // requests
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // self_x, self_y, self_z, other_x, other_y, other_z, self_radius,
  // other_radius, rest_gap, stiffness, pressure
  input  logic [223:0]         in_tdata,
  // results
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // force_x, force_y, force_z, overlapping, stretch_exceeded, degenerate,
  // saturated, zero pad
  output logic [103:0]         out_tdata
);

  localparam logic [M_W-1:0] POS_LIM = M_W'(64'h7FFF_FFFF);
  localparam logic [M_W-1:0] NEG_LIM = M_W'(64'h8000_0000);

  logic en;
  logic [STRETCH_W-1:0] max_stretch_r;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_stretch_r <= MAX_STRETCH_RST;
    end else if (cfg_wr_en) begin
      max_stretch_r <= cfg_wr_data;
    end
  end

  // stage 1: centre differences
  logic                         v1_r;
  logic [2:0][DIFF_W-1:0]       d1_r;
  prm_t                         p1_r;
  logic [2:0][COORD_W-1:0]      self_c, other_c;

  assign self_c  = in_tdata[3*COORD_W-1:0];
  assign other_c = in_tdata[6*COORD_W-1:3*COORD_W];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i] <= DIFF_W'($signed(other_c[i])) - DIFF_W'($signed(self_c[i]));
      end
      p1_r.rs   <= in_tdata[6*COORD_W +: PRM_W];
      p1_r.ro   <= in_tdata[6*COORD_W+PRM_W +: PRM_W];
      p1_r.rest <= in_tdata[6*COORD_W+2*PRM_W +: PRM_W];
      p1_r.k    <= in_tdata[6*COORD_W+3*PRM_W +: PRM_W];
      p1_r.pres <= in_tdata[6*COORD_W+4*PRM_W +: PRM_W];
    end
  end

  // stage 2: magnitudes and squares
  logic                      v2_r;
  logic [2:0]                sgn2_r;
  logic [2:0][MAG_W-1:0]     mag2_r;
  logic [2:0][2*MAG_W-1:0]   sq2_r;
  prm_t                      p2_r;
  logic [2:0][MAG_W-1:0]     mag1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag1[i] = MAG_W'(d1_r[i][DIFF_W-1] ? (DIFF_W'(0) - d1_r[i]) : d1_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sgn2_r[i] <= d1_r[i][DIFF_W-1];
        sq2_r[i]  <= mag1[i] * mag1[i];
      end
      mag2_r <= mag1;
      p2_r   <= p1_r;
    end
  end

  // stage 3: sum of squares
  logic [SQ_W-1:0] sum3_r;
  sq_sb_t          sb3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sb3_r.valid <= 1'b0;
    else if (en) sb3_r.valid <= v2_r;
    if (en) begin
      sum3_r    <= SQ_W'(sq2_r[0]) + SQ_W'(sq2_r[1]) + SQ_W'(sq2_r[2]);
      sb3_r.sgn <= sgn2_r;
      sb3_r.mag <= mag2_r;
      sb3_r.prm <= p2_r;
    end
  end

  // square root, with the record delayed alongside
  logic [ROOT_W-1:0] ctr_len;
  sq_sb_t            sqsb_r [SQRT_STAGES];

  cpsf_isqrt u_isqrt (
    .clk    (clk),
    .en     (en),
    .rad_i  (sum3_r),
    .root_o (ctr_len)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < SQRT_STAGES; j++) sqsb_r[j] <= '0;
    end else if (en) begin
      sqsb_r[0] <= sb3_r;
      for (int j = 1; j < SQRT_STAGES; j++) sqsb_r[j] <= sqsb_r[j-1];
    end
  end

  // stage 4: surface gap, deviation and flags
  sq_sb_t                    sqo;
  logic signed [GAP_W-1:0]   gap, dev;
  logic                      neg;
  logic [DELTA_W-1:0]        delta;
  mid_t                      m4_r;
  logic [DELTA_W-1:0]        delta4_r;
  logic [PRM_W-1:0]          k4_r;

  always_comb begin
    sqo   = sqsb_r[SQRT_STAGES-1];
    gap   = $signed(GAP_W'(ctr_len)) - $signed(GAP_W'(sqo.prm.rs))
          - $signed(GAP_W'(sqo.prm.ro));
    dev   = gap - $signed(GAP_W'(sqo.prm.rest));
    neg   = dev[GAP_W-1];
    delta = DELTA_W'(neg ? (GAP_W'(0) - dev) : dev);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m4_r.valid <= 1'b0;
    else if (en) m4_r.valid <= sqo.valid;
    if (en) begin
      m4_r.cneg    <= sqo.sgn ^ {3{neg}};
      m4_r.mag     <= sqo.mag;
      m4_r.over    <= gap[GAP_W-1];
      m4_r.stretch <= (delta > DELTA_W'(max_stretch_r));
      m4_r.degen   <= (ctr_len == '0);
      m4_r.ctr_len <= ctr_len;
      m4_r.pres    <= sqo.prm.pres;
      delta4_r     <= delta;
      k4_r         <= sqo.prm.k;
    end
  end

  // stage 5: stiffness times deviation
  mid_t                      m5_r;
  logic [M_W-1:0]            mk5_r;
  logic [PRM_W+DELTA_W-1:0]  kd;

  assign kd = k4_r * delta4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m5_r.valid <= 1'b0;
    else if (en) m5_r.valid <= m4_r.valid;
    if (en) begin
      m5_r[$bits(mid_t)-2:0] <= m4_r[$bits(mid_t)-2:0];
      mk5_r                  <= kd[FRAC_BITS +: M_W];
    end
  end

  // stage 6: pressure scaling on overlap
  mid_t                   m6_r;
  logic [M_W-1:0]         m6v_r;
  logic [M_W+PRM_W-1:0]   mp;

  assign mp = mk5_r * m5_r.pres;

  always_ff @(posedge clk) begin
    if (!rst_n) m6_r.valid <= 1'b0;
    else if (en) m6_r.valid <= m5_r.valid;
    if (en) begin
      m6_r[$bits(mid_t)-2:0] <= m5_r[$bits(mid_t)-2:0];
      m6v_r                  <= m5_r.over ? mp[FRAC_BITS +: M_W] : mk5_r;
    end
  end

  // stage 7: numerators m * |d|
  dv_sb_t                  sb7_r;
  logic [2:0][NUM_W-1:0]   num7_r;
  logic [ROOT_W-1:0]       dist7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sb7_r.valid <= 1'b0;
    else if (en) sb7_r.valid <= m6_r.valid;
    if (en) begin
      for (int i = 0; i < 3; i++) num7_r[i] <= m6v_r * m6_r.mag[i];
      sb7_r.cneg    <= m6_r.cneg;
      sb7_r.over    <= m6_r.over;
      sb7_r.stretch <= m6_r.stretch;
      sb7_r.degen   <= m6_r.degen;
      dist7_r       <= m6_r.ctr_len;
    end
  end

  // division by the centre distance
  logic [2:0][M_W-1:0] q;
  dv_sb_t              dvsb_r [DIV_STAGES];

  cpsf_div u_div (
    .clk    (clk),
    .en     (en),
    .num_i  (num7_r),
    .dist_i (dist7_r),
    .q_o    (q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DIV_STAGES; j++) dvsb_r[j] <= '0;
    end else if (en) begin
      dvsb_r[0] <= sb7_r;
      for (int j = 1; j < DIV_STAGES; j++) dvsb_r[j] <= dvsb_r[j-1];
    end
  end

  // final stage: sign, clipping, degenerate override
  dv_sb_t                    dvo;
  logic [2:0][FORCE_W-1:0]   frc;
  logic [2:0]                clip;
  logic                      fin_v_r;
  logic [103:0]              fin_r;

  always_comb begin
    dvo = dvsb_r[DIV_STAGES-1];
    for (int i = 0; i < 3; i++) begin
      if (dvo.cneg[i]) begin
        clip[i] = (q[i] > NEG_LIM);
        frc[i]  = clip[i] ? FORCE_W'(NEG_LIM) : FORCE_W'(M_W'(0) - q[i]);
      end else begin
        clip[i] = (q[i] > POS_LIM);
        frc[i]  = clip[i] ? FORCE_W'(POS_LIM) : FORCE_W'(q[i]);
      end
      if (dvo.degen) begin
        clip[i] = 1'b0;
        frc[i]  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fin_v_r <= 1'b0;
    else if (en) fin_v_r <= dvo.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= {4'b0000, |clip, dvo.degen, dvo.stretch, dvo.over, frc[2], frc[1], frc[0]};
    end
  end

  // output register with skid
  logic         out_v_r, skid_v_r;
  logic [103:0] out_d_r, skid_d_r;
  logic         fire, push;

  assign en        = !skid_v_r;
  assign in_tready = en;
  assign fire      = out_v_r && out_tready;
  assign push      = en && fin_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (fire) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (fire || !out_v_r) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (fire) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (fire) out_d_r <= skid_d_r;
    end else if (push) begin
      if (fire || !out_v_r) out_d_r <= fin_r;
      else skid_d_r <= fin_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

// ----- design/cpsf_checker.sv -----
// Port-level checker of the spring force block, bound to the top level.
`timescale 1ns / 1ps
`include "cell_pair_spring_force_assert.svh"
module cpsf_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  // a held result keeps its value
  `CPSF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // coinciding centres give zero force and no clipping
  `CPSF_ASSERT_NOW(a_degen_zero, out_tvalid && out_tdata[98], out_tdata[95:0] == 96'd0 && !out_tdata[99])

  // a clip flag needs a component at a 32-bit limit
  `CPSF_ASSERT_NOW(a_sat_limit, out_tvalid && out_tdata[99], out_tdata[31:0] == 32'h7FFF_FFFF || out_tdata[31:0] == 32'h8000_0000 || out_tdata[63:32] == 32'h7FFF_FFFF || out_tdata[63:32] == 32'h8000_0000 || out_tdata[95:64] == 32'h7FFF_FFFF || out_tdata[95:64] == 32'h8000_0000)

  // backpressure on requests only follows a stalled result
  `CPSF_ASSERT_NOW(a_ready_cause, !in_tready, $past(out_tvalid && !out_tready))

endmodule

bind cell_pair_spring_force cpsf_checker u_cpsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
